@@ hw/rtl/knat_pkg.sv @@
// Package for the keyed name alias table: sizes, operation and status codes,
// and the command record passed from the front end to the back end.
// No dependencies.
`default_nettype none
package knat_pkg;
    localparam int MAX_ENTRIES_DEF = 32;
    localparam int NAME_STORE_DEF  = 244;

    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_MATCH = 2'd1;
    localparam logic [1:0] FUNC_ROOT  = 2'd2;
    localparam logic [1:0] FUNC_NONE  = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_LONG = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] dir_node;
        logic [31:0] old_root;
        logic [31:0] target_node;
        logic [7:0]  key_len;
    } knat_cmd_t;
endpackage
`default_nettype wire

@@ hw/rtl/knat_if.sv @@
// Valid/ready channel interfaces for the keyed name alias table.
// Depends on nothing.
`default_nettype none
interface knat_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] dir_node;
    logic [31:0] old_root;
    logic [31:0] target_node;
    logic [7:0]  name_byte;
    logic        byte_present;
    logic        name_last;
    modport source (output valid, func, dir_node, old_root, target_node, name_byte,
                    byte_present, name_last, input ready);
    modport sink (input valid, func, dir_node, old_root, target_node, name_byte,
                  byte_present, name_last, output ready);
endinterface

interface knat_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] result_value;
    modport source (output valid, status, result_value, input ready);
    modport sink (input valid, status, result_value, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/keyed_name_alias_table_top.sv @@
// Top level of the keyed name alias table: front end, command register, back end.
// Depends on knat_pkg, knat_if, knat_front and knat_back.
//
// Input transactions carry at most one name byte each; the transaction with name_last
// set runs the operation (add, match or set root) on the buffered key.
// Each such transaction with a valid operation gives one output transaction.
// A byte-only transaction leaves ready high. Add copies the key into the name
// memory, one key byte per cycle through the name memory port;
// match walks the entries one per cycle and compares a candidate name one
// byte per cycle; set root walks the entries once, one per cycle, and then
// writes the two bytes of the root name.
// While an operation runs or its result waits, ready is low; the result
// stays in the output register until the receiver takes it.
// Reset empties the table to the single root entry with a zero directory,
// zero target and empty name, and clears the key.
`default_nettype none
module keyed_name_alias_table_top
    import knat_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int NAME_STORE  = NAME_STORE_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    knat_in_if.sink    in_ch,
    knat_out_if.source out_ch
);
    logic       busy;
    logic       cmd_valid;
    knat_cmd_t  cmd;
    logic [7:0] key_raddr;
    logic [7:0] key_rdata;

    knat_front #(.NAME_STORE(NAME_STORE)) u_front
    (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .busy(busy),
        .key_raddr(key_raddr), .key_rdata(key_rdata),
        .cmd_valid(cmd_valid), .cmd(cmd)
    );

    knat_back #(.MAX_ENTRIES(MAX_ENTRIES), .NAME_STORE(NAME_STORE)) u_back
    (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd), .busy(busy),
        .key_raddr(key_raddr), .key_rdata(key_rdata), .out_ch(out_ch)
    );
endmodule
`default_nettype wire

@@ hw/rtl/knat_front.sv @@
// Front end: buffers key bytes; one command per name_last transaction unless FUNC_NONE.
// Depends on knat_pkg and knat_if. The key buffer is shared with the back end.
`default_nettype none
module knat_front
    import knat_pkg::*;
#(
    parameter int NAME_STORE = NAME_STORE_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    knat_in_if.sink         in_ch,
    input  wire logic       busy,
    input  wire logic [7:0] key_raddr,
    output logic [7:0]      key_rdata,
    output logic            cmd_valid,
    output knat_cmd_t       cmd
);
    logic [7:0] key_mem [NAME_STORE];
    logic [7:0] key_len_reg, key_len_next;
    logic       acc;

    assign in_ch.ready = !busy && !cmd_valid;
    assign acc = in_ch.valid && in_ch.ready;

    always_comb
    begin
        key_len_next = key_len_reg;
        if (acc)
        begin
            if (in_ch.name_last)
                key_len_next = 8'd0;
            else if (in_ch.byte_present && key_len_reg != 8'd255)
                key_len_next = key_len_reg + 8'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && in_ch.byte_present && 32'(key_len_reg) < NAME_STORE)
            key_mem[key_len_reg[$clog2(NAME_STORE)-1:0]] <= in_ch.name_byte;
        key_rdata <= key_mem[key_raddr[$clog2(NAME_STORE)-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_len_reg <= 8'd0;
            cmd_valid   <= 1'b0;
        end
        else
        begin
            key_len_reg <= key_len_next;
            cmd_valid   <= 1'b0;
            if (acc && in_ch.name_last && in_ch.func != FUNC_NONE)
                cmd_valid <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            cmd.func        <= in_ch.func;
            cmd.dir_node    <= in_ch.dir_node;
            cmd.old_root    <= in_ch.old_root;
            cmd.target_node <= in_ch.target_node;
            cmd.key_len     <= (in_ch.byte_present && key_len_reg != 8'd255)
                               ? key_len_reg + 8'd1 : key_len_reg;
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/knat_back.sv @@
// Back end: sequencer that runs add, match and set-root over the entry tables.
// Depends on knat_pkg and knat_if; reads key bytes from the front end.
`default_nettype none
module knat_back
    import knat_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int NAME_STORE  = NAME_STORE_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cmd_valid,
    input  wire knat_cmd_t  cmd,
    output logic            busy,
    output logic [7:0]      key_raddr,
    input  wire logic [7:0] key_rdata,
    knat_out_if.source      out_ch
);
    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int NW = $clog2(MAX_ENTRIES * NAME_STORE);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_COPY = 3'd1;
    localparam logic [2:0] S_MENT = 3'd2;
    localparam logic [2:0] S_MCMP = 3'd3;
    localparam logic [2:0] S_ROOT = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;
    localparam logic [2:0] S_RNAM = 3'd6;

    localparam logic [7:0] ROOT_CHAR = 8'h2f;

    logic [31:0] dir_mem [MAX_ENTRIES];
    logic [31:0] tgt_mem [MAX_ENTRIES];
    logic [7:0]  len_mem [MAX_ENTRIES];
    logic [7:0]  name_mem [MAX_ENTRIES * NAME_STORE];

    logic [2:0]    state_reg;
    logic [CW-1:0] count_reg;
    knat_cmd_t     cmd_reg;
    logic [IW-1:0] idx_reg;
    logic [8:0]    pos_reg;
    logic [1:0]    stat_reg;
    logic [31:0]   val_reg;
    logic          phase_reg;
    logic [7:0]    nrd;
    logic [NW-1:0] base;
    logic          nm_we;
    logic [NW-1:0] nm_waddr;
    logic [7:0]    nm_wdata;

    assign busy = (state_reg != S_IDLE) || out_ch.valid;
    assign key_raddr = pos_reg[7:0];
    assign base = NW'(idx_reg) * NW'(NAME_STORE);

    always_comb
    begin
        nm_we    = 1'b0;
        nm_waddr = base + NW'(pos_reg[7:0]) - NW'(1);
        nm_wdata = key_rdata;
        case (state_reg)
            S_COPY:
            begin
                nm_we = phase_reg;
                if (pos_reg[7:0] == cmd_reg.key_len + 8'd1)
                    nm_wdata = 8'd0;
            end
            S_RNAM:
            begin
                nm_we    = 1'b1;
                nm_waddr = phase_reg ? NW'(1) : NW'(0);
                nm_wdata = phase_reg ? 8'd0 : ROOT_CHAR;
            end
            default:
                nm_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (nm_we)
            name_mem[nm_waddr] <= nm_wdata;
        nrd <= name_mem[base + NW'(pos_reg[7:0])];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= CW'(1);
            out_ch.valid <= 1'b0;
            idx_reg      <= '0;
            pos_reg      <= '0;
            phase_reg    <= 1'b0;
            dir_mem[0]   <= '0;
            tgt_mem[0]   <= '0;
            len_mem[0]   <= '0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
                out_ch.valid <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cmd_reg   <= cmd;
                        stat_reg  <= ST_OK;
                        val_reg   <= '0;
                        pos_reg   <= '0;
                        phase_reg <= 1'b0;
                        case (cmd.func)
                            FUNC_ADD:
                            begin
                                if (32'(count_reg) >= MAX_ENTRIES)
                                begin
                                    stat_reg  <= ST_FULL;
                                    state_reg <= S_OUT;
                                end
                                else if (32'(cmd.key_len) >= NAME_STORE - 1)
                                begin
                                    stat_reg  <= ST_LONG;
                                    state_reg <= S_OUT;
                                end
                                else
                                begin
                                    idx_reg   <= IW'(count_reg);
                                    state_reg <= S_COPY;
                                end
                            end
                            FUNC_MATCH:
                            begin
                                val_reg   <= '1;
                                idx_reg   <= '0;
                                state_reg <= S_MENT;
                            end
                            default:
                            begin
                                idx_reg   <= IW'(1);
                                state_reg <= S_ROOT;
                            end
                        endcase
                    end
                end
                S_COPY:
                begin
                    // first cycle only issues the key read
                    if (!phase_reg)
                    begin
                        phase_reg <= 1'b1;
                        pos_reg   <= pos_reg + 9'd1;
                    end
                    else if (pos_reg[7:0] == cmd_reg.key_len + 8'd1)
                    begin
                        dir_mem[idx_reg] <= cmd_reg.dir_node;
                        tgt_mem[idx_reg] <= cmd_reg.target_node;
                        len_mem[idx_reg] <= cmd_reg.key_len;
                        count_reg <= count_reg + CW'(1);
                        val_reg   <= 32'd0 - 32'(count_reg + CW'(1));
                        state_reg <= S_OUT;
                    end
                    else
                        pos_reg <= pos_reg + 9'd1;
                end
                S_MENT:
                begin
                    if (32'(idx_reg) >= 32'(count_reg))
                        state_reg <= S_OUT;
                    else if (dir_mem[idx_reg] == cmd_reg.dir_node
                             && len_mem[idx_reg] == cmd_reg.key_len)
                    begin
                        pos_reg   <= '0;
                        phase_reg <= 1'b0;
                        state_reg <= S_MCMP;
                    end
                    else if (32'(idx_reg) == MAX_ENTRIES - 1)
                        state_reg <= S_OUT;
                    else
                        idx_reg <= idx_reg + IW'(1);
                end
                S_MCMP:
                begin
                    // compare byte pos-1 once both reads are back
                    if (!phase_reg && 32'(cmd_reg.key_len) != 0)
                    begin
                        phase_reg <= 1'b1;
                        pos_reg   <= pos_reg + 9'd1;
                    end
                    else if (32'(cmd_reg.key_len) == 0
                             || (pos_reg[7:0] == cmd_reg.key_len && nrd == key_rdata))
                    begin
                        val_reg   <= tgt_mem[idx_reg];
                        state_reg <= S_OUT;
                    end
                    else if (nrd != key_rdata)
                    begin
                        if (32'(idx_reg) == MAX_ENTRIES - 1)
                            state_reg <= S_OUT;
                        else
                        begin
                            idx_reg   <= idx_reg + IW'(1);
                            state_reg <= S_MENT;
                        end
                    end
                    else
                        pos_reg <= pos_reg + 9'd1;
                end
                S_ROOT:
                begin
                    if (32'(idx_reg) < 32'(count_reg) && dir_mem[idx_reg] == cmd_reg.old_root)
                        dir_mem[idx_reg] <= cmd_reg.dir_node;
                    if (32'(idx_reg) + 1 >= 32'(count_reg) || 32'(idx_reg) == MAX_ENTRIES - 1)
                    begin
                        dir_mem[0] <= cmd_reg.dir_node;
                        tgt_mem[0] <= cmd_reg.dir_node;
                        len_mem[0] <= 8'd2;
                        phase_reg  <= 1'b0;
                        state_reg  <= S_RNAM;
                    end
                    else
                        idx_reg <= idx_reg + IW'(1);
                end
                S_RNAM:
                begin
                    if (!phase_reg)
                        phase_reg <= 1'b1;
                    else
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    out_ch.valid  <= 1'b1;
                    out_ch.status <= stat_reg;
                    out_ch.result_value <= val_reg;
                    state_reg     <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ tb/knat_checker.sv @@
// Checker for the keyed name alias table: watches both channels, predicts each
// result from its own copy of the table and compares. Depends on knat_pkg, knat_if.
`timescale 1ns / 100ps
module knat_checker
    import knat_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    knat_in_if.sink     in_mon,
    knat_out_if.sink    out_mon,
    output int          fail_count,
    output int          pending,
    output int          results_seen
);
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value;
    } alias_result_t;

    localparam int MAXE = MAX_ENTRIES_DEF;
    localparam int NSTORE = NAME_STORE_DEF;

    logic [31:0] tbl_dir [MAXE];
    logic [31:0] tbl_target [MAXE];
    int          tbl_len [MAXE];
    logic [7:0]  tbl_name [MAXE][NSTORE];
    int          tbl_count;
    logic [7:0]  key_bytes [NSTORE];
    int          key_len;
    alias_result_t expected_results [$];

    function automatic bit entry_matches(int idx, logic [31:0] dir);
        if (tbl_dir[idx] != dir || tbl_len[idx] != key_len)
            return 0;
        for (int k = 0; k < key_len && k < NSTORE; k++)
            if (tbl_name[idx][k] != key_bytes[k])
                return 0;
        return 1;
    endfunction

    task automatic apply_transaction();
        alias_result_t r;
        int idx;
        r = '0;
        if (in_mon.byte_present)
        begin
            if (key_len < NSTORE)
                key_bytes[key_len] = in_mon.name_byte;
            if (key_len < 255)
                key_len++;
        end
        if (!in_mon.name_last)
            return;
        case (in_mon.func)
            FUNC_ADD:
            begin
                if (tbl_count >= MAXE)
                    r.status = ST_FULL;
                else if (key_len >= NSTORE - 1)
                    r.status = ST_LONG;
                else
                begin
                    idx = tbl_count;
                    tbl_dir[idx] = in_mon.dir_node;
                    tbl_target[idx] = in_mon.target_node;
                    tbl_len[idx] = key_len;
                    for (int i = 0; i < key_len; i++)
                        tbl_name[idx][i] = key_bytes[i];
                    tbl_name[idx][key_len] = 8'd0;
                    tbl_count++;
                    r.value = -tbl_count;
                end
                expected_results.push_back(r);
            end
            FUNC_MATCH:
            begin
                r.value = '1;
                for (int i = 0; i < tbl_count; i++)
                    if (entry_matches(i, in_mon.dir_node))
                    begin
                        r.value = tbl_target[i];
                        break;
                    end
                expected_results.push_back(r);
            end
            FUNC_ROOT:
            begin
                for (int i = 1; i < tbl_count; i++)
                    if (tbl_dir[i] == in_mon.old_root)
                        tbl_dir[i] = in_mon.dir_node;
                tbl_dir[0] = in_mon.dir_node;
                tbl_target[0] = in_mon.dir_node;
                tbl_len[0] = 2;
                tbl_name[0][0] = "/";
                tbl_name[0][1] = 8'd0;
                expected_results.push_back(r);
            end
            default: ;
        endcase
        key_len = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tbl_dir[0] = '0;
            tbl_target[0] = '0;
            tbl_len[0] = 0;
            tbl_count = 1;
            key_len = 0;
            expected_results.delete();
            fail_count <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (out_mon.valid && out_mon.ready)
            begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result transaction: status %0d value %0d",
                           out_mon.status, $signed(out_mon.result_value));
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    alias_result_t e;
                    e = expected_results.pop_front();
                    if (e.status != out_mon.status || e.value != out_mon.result_value)
                        fail_count <= fail_count + 1;
                    if (e.status != out_mon.status)
                        $error("status: expected %0d, actual %0d", e.status, out_mon.status);
                    if (e.value != out_mon.result_value)
                        $error("result_value: expected %0d, actual %0d",
                               $signed(e.value), $signed(out_mon.result_value));
                end
            end
            if (in_mon.valid && in_mon.ready)
                apply_transaction();
        end
        pending = expected_results.size();
    end
endmodule

@@ tb/keyed_name_alias_table_top_tb.sv @@
// Testbench top for the keyed name alias table: drives names and operations,
// stalls the receiver, and reports the verdict. Depends on knat_pkg, knat_if,
// knat_checker and the block itself.
`timescale 1ns / 100ps
module keyed_name_alias_table_top_tb
    import knat_pkg::*;
;
    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   results_seen;
    int   sent_count;
    bit   long_hold;
    logic [31:0] dir_pool [4];
    logic [7:0]  name_pool [4][8];
    int          name_len_pool [4];

    knat_in_if  in_ch ();
    knat_out_if out_ch ();

    keyed_name_alias_table_top dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

    knat_checker checker_inst (
        .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
        .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_item(logic [1:0] f, logic [31:0] d, logic [31:0] o, logic [31:0] t,
                             logic [7:0] b, logic p, logic l);
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.func <= f;
        in_ch.dir_node <= d;
        in_ch.old_root <= o;
        in_ch.target_node <= t;
        in_ch.name_byte <= b;
        in_ch.byte_present <= p;
        in_ch.name_last <= l;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sent_count++;
    endtask

    task automatic send_name_op(logic [1:0] f, logic [31:0] d, logic [31:0] o,
                                logic [31:0] t, int len, int pool);
        logic [7:0] b;
        if (len == 0)
        begin
            send_item(f, d, o, t, 8'($urandom), 1'b0, 1'b1);
            return;
        end
        for (int i = 0; i < len; i++)
        begin
            b = (pool >= 0 && i < name_len_pool[pool]) ? name_pool[pool][i] : 8'($urandom);
            send_item(f, d, o, t, b, 1'b1, i == len - 1);
        end
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int gap;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_ch.ready <= 1'b0;
                repeat (300) @(posedge clk);
                long_hold = 0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            if (gap == 0)
                out_ch.ready <= 1'b1;
            else
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int pool;
        int len;
        int op;
        in_ch.valid = 1'b0;
        in_ch.func = FUNC_ADD;
        in_ch.dir_node = '0;
        in_ch.old_root = '0;
        in_ch.target_node = '0;
        in_ch.name_byte = '0;
        in_ch.byte_present = 1'b0;
        in_ch.name_last = 1'b0;
        sent_count = 0;
        long_hold = 0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            dir_pool[i] = (i == 0) ? 32'h0 : (i == 1 ? 32'h7FFF_FFFF : $urandom);
            name_len_pool[i] = i * 2;
            for (int k = 0; k < 8; k++)
                name_pool[i][k] = (i == 1) ? 8'hFF : 8'($urandom);
        end
        @(posedge clk);

        // Directed: root entry, extremes, empty names, byte-only, unused code.
        send_name_op(FUNC_MATCH, 32'h0, 32'h0, 32'h0, 0, -1);
        send_name_op(FUNC_ADD, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 0, -1);
        send_name_op(FUNC_MATCH, 32'h8000_0000, 32'h0, 32'h0, 0, -1);
        send_name_op(FUNC_ADD, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 2, 1);
        send_name_op(FUNC_MATCH, 32'h7FFF_FFFF, 32'h0, 32'h0, 2, 1);
        send_item(FUNC_NONE, 32'h0, 32'h0, 32'h0, 8'h00, 1'b1, 1'b1);
        send_name_op(FUNC_ROOT, 32'h1234, 32'h8000_0000, 32'h0, 0, -1);
        send_item(FUNC_MATCH, 32'h1234, 32'h0, 32'h0, "/", 1'b1, 1'b0);
        send_item(FUNC_MATCH, 32'h1234, 32'h0, 32'h0, 8'h00, 1'b1, 1'b1);
        send_name_op(FUNC_MATCH, 32'h1234, 32'h0, 32'h0, 0, -1);
        send_name_op(FUNC_ADD, 32'h5, 32'h0, 32'h9, 242, -1);
        send_name_op(FUNC_ADD, 32'h5, 32'h0, 32'h9, 243, -1);
        wait_drained();

        // Sender pause done above; now a long receiver hold-off with traffic
        // that also fills the table.
        long_hold = 1;
        for (int i = 0; i < 32; i++)
            send_name_op(FUNC_ADD, dir_pool[i % 4], 32'h0, 32'(i), name_len_pool[i % 4],
                         i % 4);
        wait_drained();

        // Random: mostly pooled keys so that matches hit.
        while (sent_count < 700)
        begin
            op = $urandom_range(0, 19);
            pool = $urandom_range(0, 3);
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8) : name_len_pool[pool];
            if (op < 8)
                send_name_op(FUNC_ADD, dir_pool[$urandom_range(0, 3)], $urandom, $urandom,
                             len, pool);
            else if (op < 17)
                send_name_op(FUNC_MATCH, dir_pool[$urandom_range(0, 3)], $urandom, $urandom,
                             len, pool);
            else if (op < 19)
                send_name_op(FUNC_ROOT, dir_pool[$urandom_range(0, 3)],
                             dir_pool[$urandom_range(0, 3)], $urandom, 0, -1);
            else
                send_item(FUNC_NONE, $urandom, $urandom, $urandom, 8'($urandom),
                          1'($urandom), 1'b1);
        end
        wait_drained();
        repeat (600) @(posedge clk);
        $display("Run covered %0d input and %0d result transactions: add, match, set root,",
                 sent_count, results_seen);
        $display("table full, over-long names, empty names and a long output stall.");
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
